>>> src/dcra_pkg.sv
// ----------------------------------------------------------------------------
// dcra_pkg: shared constants and fixed-point helpers
// Holds the sine coefficients, Q30 rounding helpers and widths used by the
// radiation amplitude pipeline.
// ----------------------------------------------------------------------------
package dcra_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int AMP_FRAC_BITS_DEF = 14;
  localparam int CFG_W             = 16;
  localparam int IN_W              = 16;
  localparam int AMP_W             = 16;
  localparam int IDX_W             = 2;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_RAKE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIP    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DAZ    = 2'd2;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  // Wave kind selector codes.
  localparam logic [1:0] KIND_P   = 2'd0;
  localparam logic [1:0] KIND_SV  = 2'd1;
  localparam logic [1:0] KIND_SH  = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Q30 values are held in 33-bit signed words, since one plus a squared
  // sine can reach exactly 2^31.
  typedef logic signed [32:0] q30_t;

  localparam q30_t ONE_Q30  = 33'sd1073741824;
  localparam q30_t HALF_Q30 = 33'sd536870912;
  localparam q30_t C1 = 33'sd1686629713;
  localparam q30_t C3 = 33'sd693598669;
  localparam q30_t C5 = 33'sd85569298;
  localparam q30_t C7 = 33'sd5026995;
  localparam q30_t C9 = 33'sd172272;

  // Q30 product rounded to nearest, ties away from zero.
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    logic [63:0]        mag;
    logic [63:0]        r;
    p   = 64'(a) * 64'(b);
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = (mag + 64'(1 << 29)) >> 30;
    mulq = p[63] ? q30_t'(-$signed(r)) : q30_t'(r);
  endfunction

endpackage

>>> src/double_couple_radiation_amplitude_top.sv
// ----------------------------------------------------------------------------
// double_couple_radiation_amplitude_top: double-couple radiation amplitude
// Far-field P, SV and SH amplitude of a shear source for one ray per request.
// ----------------------------------------------------------------------------
// Usage: write rake, dip and dip azimuth through the cfg_ port (index 0, 1,
// 2; other indexes are ignored) while no request is in flight. A request is
// taken at every clock edge where start is high; busy is always low, so one
// ray can be issued in every cycle. Each request produces exactly one result:
// out_amplitude (signed Q2.14) and out_bad_kind, marked by out_valid for one
// cycle. The path runs through one input register, eight stages in the
// sine/cosine pipelines, then five product and rounding stages.
// Throughput is one request per cycle, set by the fully pipelined trig and
// product units.
// A valid bit shift line travels beside the data so that results come out in
// request order. Reset clears the config registers and the valid line; no
// results are emitted until a new request arrives. The receiver cannot
// stall, so no backpressure path exists.
// ----------------------------------------------------------------------------
module double_couple_radiation_amplitude_top #(
  parameter int ANGLE_BITS    = dcra_pkg::ANGLE_BITS_DEF,
  parameter int AMP_FRAC_BITS = dcra_pkg::AMP_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [15:0]                       in_ray_takeoff,
  input  logic [15:0]                       in_ray_azimuth,
  input  logic [1:0]                        in_opcode,
  output logic                              out_valid,
  output logic signed [dcra_pkg::AMP_W-1:0] out_amplitude,
  output logic                              out_bad_kind,
  input  logic                              cfg_we,
  input  logic [dcra_pkg::IDX_W-1:0]        cfg_index,
  input  logic [dcra_pkg::CFG_W-1:0]        cfg_data
);
  import dcra_pkg::*;

  localparam int LAT = 14;
  localparam int PAD = 32 - ANGLE_BITS;

  logic [ANGLE_BITS-1:0] rake_r, dip_r, daz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rake_r <= '0; dip_r <= '0; daz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAKE: rake_r <= ANGLE_BITS'(cfg_data);
        REG_DIP:  dip_r  <= ANGLE_BITS'(cfg_data);
        REG_DAZ:  daz_r  <= ANGLE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 0: register the turn fractions of all angles.
  logic [31:0] tl_r, td_r, ti_r, tp_r;
  logic [1:0]  k0_r;
  always_ff @(posedge clk) begin
    tl_r <= {rake_r, PAD'(0)};
    td_r <= {dip_r, PAD'(0)};
    ti_r <= {ANGLE_BITS'(in_ray_takeoff), PAD'(0)};
    tp_r <= {ANGLE_BITS'(in_ray_azimuth), PAD'(0)} - {daz_r, PAD'(0)};
    k0_r <= in_opcode;
  end

  localparam logic [31:0] QT = 32'h4000_0000;
  logic [31:0] targ [0:13];
  q30_t        tv   [0:13];
  assign targ[0]  = tl_r;           assign targ[1]  = tl_r + QT;
  assign targ[2]  = td_r;           assign targ[3]  = td_r + QT;
  assign targ[4]  = td_r << 1;      assign targ[5]  = (td_r << 1) + QT;
  assign targ[6]  = ti_r;           assign targ[7]  = ti_r + QT;
  assign targ[8]  = ti_r << 1;      assign targ[9]  = (ti_r << 1) + QT;
  assign targ[10] = tp_r;           assign targ[11] = tp_r + QT;
  assign targ[12] = tp_r << 1;      assign targ[13] = (tp_r << 1) + QT;

  for (genvar g = 0; g < 14; g++) begin : g_trig
    dcra_trig u_trig (.clk(clk), .turn(targ[g]), .sin_out(tv[g]));
  end

  // Opcode delay to line up with the trig outputs (eight stages).
  logic [1:0] kd_r [0:7];
  always_ff @(posedge clk) begin
    kd_r[0] <= k0_r;
    for (int j = 1; j < 8; j++) kd_r[j] <= kd_r[j-1];
  end

  dcra_comb #(.AMP_FRAC_BITS(AMP_FRAC_BITS)) u_comb (
    .clk(clk),
    .sl(tv[0]), .cl(tv[1]), .sd(tv[2]), .cd(tv[3]), .s2d(tv[4]), .c2d(tv[5]),
    .si(tv[6]), .ci(tv[7]), .s2i(tv[8]), .c2i(tv[9]),
    .sp(tv[10]), .cp(tv[11]), .s2p(tv[12]), .c2p(tv[13]),
    .kind(kd_r[7]), .amp(out_amplitude), .bad(out_bad_kind)
  );

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start};
  end
  assign out_valid = vld_r[LAT-1];

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after request");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without request");
endmodule

>>> src/dcra_trig.sv
// ----------------------------------------------------------------------------
// dcra_trig: pipelined sine of a 32-bit turn fraction
// Eight register stages fold the quadrant, evaluate the odd polynomial in Horner form and apply the sign.
// ----------------------------------------------------------------------------
module dcra_trig (
  input  logic            clk,
  input  logic [31:0]     turn,
  output dcra_pkg::q30_t  sin_out
);
  import dcra_pkg::*;

  logic [1:0] q_r [0:6];
  q30_t       z_r [0:5];
  q30_t       z2_r [1:5];
  q30_t       s_r [1:6];
  q30_t       fin_r;

  always_ff @(posedge clk) begin
    q_r[0] <= turn[31:30];
    z_r[0] <= turn[30] ? ONE_Q30 - q30_t'({2'b00, turn[29:0]})
                       : q30_t'({2'b00, turn[29:0]});
    q_r[1] <= q_r[0];
    z_r[1] <= z_r[0];
    z2_r[1] <= mulq(z_r[0], z_r[0]);
    s_r[1] <= C9;
    q_r[2] <= q_r[1];  z_r[2] <= z_r[1];  z2_r[2] <= z2_r[1];
    s_r[2] <= C7 - mulq(z2_r[1], s_r[1]);
    q_r[3] <= q_r[2];  z_r[3] <= z_r[2];  z2_r[3] <= z2_r[2];
    s_r[3] <= C5 - mulq(z2_r[2], s_r[2]);
    q_r[4] <= q_r[3];  z_r[4] <= z_r[3];  z2_r[4] <= z2_r[3];
    s_r[4] <= C3 - mulq(z2_r[3], s_r[3]);
    q_r[5] <= q_r[4];  z_r[5] <= z_r[4];
    s_r[5] <= C1 - mulq(z2_r[4], s_r[4]);
    q_r[6] <= q_r[5];
    s_r[6] <= mulq(z_r[5], s_r[5]);
    if (s_r[6] < 0)
      fin_r <= '0;
    else if (s_r[6] > ONE_Q30)
      fin_r <= q_r[6][1] ? -ONE_Q30 : ONE_Q30;
    else
      fin_r <= q_r[6][1] ? -s_r[6] : s_r[6];
  end

  assign sin_out = fin_r;
endmodule

>>> src/dcra_comb.sv
// ----------------------------------------------------------------------------
// dcra_comb: pattern products and sum
// Forms the three radiation patterns from the trig values over registered
// product stages and rounds the chosen sum to the output format.
// ----------------------------------------------------------------------------
module dcra_comb #(
  parameter int AMP_FRAC_BITS = dcra_pkg::AMP_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  dcra_pkg::q30_t                sl, cl, sd, cd, s2d, c2d,
  input  dcra_pkg::q30_t                si, ci, s2i, c2i, sp, cp, s2p, c2p,
  input  logic [1:0]                    kind,
  output logic signed [dcra_pkg::AMP_W-1:0] amp,
  output logic                          bad
);
  import dcra_pkg::*;

  localparam int SH = 30 - AMP_FRAC_BITS;

  // Stage A: first-level products.
  q30_t a_clsd, a_clcd, a_slsd2, a_slc2d, a_sisi, a_sisp, a_cici;
  q30_t a_hcl, a_hsl, a_spsp;
  q30_t a_s2i, a_c2i, a_sp, a_cp, a_s2p, a_c2p, a_si, a_ci, a_sd, a_s2d;
  logic [1:0] a_k;
  always_ff @(posedge clk) begin
    a_clsd <= mulq(cl, sd);   a_clcd <= mulq(cl, cd);
    a_slsd2 <= mulq(sl, s2d); a_slc2d <= mulq(sl, c2d);
    a_sisi <= mulq(si, si);   a_sisp <= mulq(si, sp);
    a_cici <= mulq(ci, ci);   a_spsp <= mulq(sp, sp);
    a_hcl <= mulq(HALF_Q30, cl); a_hsl <= mulq(HALF_Q30, sl);
    a_s2i <= s2i; a_c2i <= c2i; a_sp <= sp; a_cp <= cp; a_s2p <= s2p;
    a_c2p <= c2p; a_si <= si; a_ci <= ci; a_sd <= sd; a_s2d <= s2d;
    a_k <= kind;
  end

  // Stage B: second-level products.
  q30_t b_p1, b_p2, b_inner, b_p4, b_v1, b_v2, b_v3, b_v4, b_onep;
  q30_t b_h1, b_h2, b_h3, b_h4;
  q30_t b_s2p, b_cp, b_sp, b_c2p, b_s2i, b_si;
  logic [1:0] b_k;
  always_ff @(posedge clk) begin
    b_p1 <= mulq(a_clsd, a_sisi);
    b_p2 <= mulq(a_clcd, a_s2i);
    b_inner <= a_cici - mulq(a_sisp, a_sisp);
    b_p4 <= mulq(a_slc2d, a_s2i);
    b_v1 <= mulq(a_slc2d, a_c2i);
    b_v2 <= mulq(a_clcd, a_c2i);
    b_v3 <= mulq(a_hcl, a_sd);
    b_v4 <= mulq(a_hsl, a_s2d);
    b_onep <= ONE_Q30 + a_spsp;
    b_h1 <= mulq(a_clcd, a_ci);
    b_h2 <= mulq(a_clsd, a_si);
    b_h3 <= mulq(a_slc2d, a_ci);
    b_h4 <= mulq(a_hsl, a_s2d);
    b_s2p <= a_s2p; b_cp <= a_cp; b_sp <= a_sp; b_c2p <= a_c2p;
    b_s2i <= a_s2i; b_si <= a_si;
    b_k <= a_k;
    // a_slsd2 feeds the P inner product next stage
  end
  q30_t b_slsd2;
  always_ff @(posedge clk) b_slsd2 <= a_slsd2;

  // Stage C: third-level products.
  q30_t c_t1, c_t2, c_t3, c_t4;
  q30_t c_v3, c_v4, c_h4, c_s2p, c_onep;
  logic [1:0] c_k;
  always_ff @(posedge clk) begin
    c_v3 <= mulq(b_v3, b_s2i);
    c_v4 <= mulq(b_v4, b_s2i);
    c_h4 <= mulq(b_h4, b_si);
    c_s2p <= b_s2p; c_onep <= b_onep;
    c_k <= b_k;
    case (b_k)
      KIND_P: begin
        c_t1 <= mulq(b_p1, b_s2p);
        c_t2 <= mulq(b_p2, b_cp);
        c_t3 <= mulq(b_slsd2, b_inner);
        c_t4 <= mulq(b_p4, b_sp);
      end
      KIND_SV: begin
        c_t1 <= mulq(b_v1, b_sp);
        c_t2 <= mulq(b_v2, b_cp);
        c_t3 <= '0;
        c_t4 <= '0;
      end
      default: begin
        c_t1 <= mulq(b_h1, b_sp);
        c_t2 <= mulq(b_h2, b_c2p);
        c_t3 <= mulq(b_h3, b_cp);
        c_t4 <= '0;
      end
    endcase
  end

  // Stage D: last products and the sum.
  logic signed [35:0] d_acc;
  logic [1:0]         d_k;
  always_ff @(posedge clk) begin
    d_k <= c_k;
    case (c_k)
      KIND_P:  d_acc <= 36'(c_t1) - 36'(c_t2) + 36'(c_t3) + 36'(c_t4);
      KIND_SV: d_acc <= -(36'(c_t1) - 36'(c_t2) + 36'(mulq(c_v3, c_s2p))
                          - 36'(mulq(c_v4, c_onep)));
      KIND_SH: d_acc <= 36'(c_t1) + 36'(c_t2) + 36'(c_t3)
                        - 36'(mulq(c_h4, c_s2p));
      default: d_acc <= '0;
    endcase
  end

  // Stage E: round and saturate.
  logic [35:0]        e_mag;
  logic signed [36:0] e_r;
  always_comb begin
    e_mag = d_acc[35] ? 36'(-d_acc) : 36'(d_acc);
    e_mag = (e_mag + (36'(1) << (SH - 1))) >> SH;
    e_r   = d_acc[35] ? -$signed({1'b0, e_mag}) : $signed({1'b0, e_mag});
  end
  always_ff @(posedge clk) begin
    if (e_r > 37'sd32767)       amp <= 16'sh7fff;
    else if (e_r < -37'sd32768) amp <= 16'sh8000;
    else                        amp <= e_r[15:0];
    bad <= (d_k == KIND_BAD);
  end
endmodule
